// ----- rtl/rbmn_pkg.sv -----
// ----------------------------------------------------------------------------
// rbmn_pkg
// Shared types and constants for the cartridge ROM bank mapper with its
// built-in nibble RAM.
// ----------------------------------------------------------------------------
package rbmn_pkg;

  // Default depth of the built-in nibble RAM.
  localparam int RAM_DEPTH_DEFAULT = 512;

  // Field widths.
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int BANK_W     = 4;
  localparam int NIBBLE_W   = 4;
  localparam int ROM_ADDR_W = 18;
  localparam int BANK_OFS_W = 14;

  // Bus map.
  localparam logic [ADDR_W-1:0] RAM_EN_LIMIT = 16'h2000;
  localparam logic [ADDR_W-1:0] BANK_LIMIT   = 16'h4000;
  localparam logic [ADDR_W-1:0] ROM_LIMIT    = 16'h8000;
  localparam logic [ADDR_W-1:0] RAM_BASE     = 16'hA000;
  localparam logic [ADDR_W-1:0] RAM_WIN_LAST = 16'hBFFF;

  // Reset values.
  localparam logic [BANK_W-1:0] ROM_BANK_MASK_RESET = 4'hF;
  localparam logic [BANK_W-1:0] ROM_BANK_RESET      = 4'h1;

  // Byte returned for disabled or missing RAM.
  localparam logic [DATA_W-1:0] OPEN_BUS_BYTE = 8'hFF;

  // Configuration register indexes.
  localparam logic REG_ROM_BANK_MASK = 1'b0;

  // Access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Response kinds.
  typedef enum logic [1:0] {
    RESP_NONE = 2'd0,
    RESP_ROM  = 2'd1,
    RESP_DATA = 2'd2
  } resp_kind_t;

endpackage

// ----- rtl/rbmn_ram.sv -----
// ----------------------------------------------------------------------------
// rbmn_ram
// Generic simple dual-port RAM with one write port and one registered read
// port. The read register holds its value while the read enable is low.
// ----------------------------------------------------------------------------
module rbmn_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; a read in the same cycle as a write to that address returns the old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rom_bank_mapper_nibble_ram_unit.sv -----
// ----------------------------------------------------------------------------
// rom_bank_mapper_nibble_ram_unit
// Cartridge bank controller: decodes one bus access per word, maps ROM reads
// to physical addresses, keeps the bank and RAM-disable registers, and serves
// a built-in nibble RAM.
// ----------------------------------------------------------------------------
// Pipeline: an accepted access word passes the decode stage, then the result register.
// Throughput: one access word per cycle while m_tready holds and no clearing pass runs.
// Reset: rst clears control state, then a clearing pass writes zero to every
// RAM entry, one entry a cycle; s_tready stays low during that pass while
// configuration writes are still taken.
module rom_bank_mapper_nibble_ram_unit #(
  parameter int RAM_DEPTH = rbmn_pkg::RAM_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Access input.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] bus_address, [23:16] write_data
  input  logic [0:0]  s_tuser,   // [0] operation
  // Result output.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [17:0] rom_address, [25:18] read_data, rest 0
  output logic [1:0]  m_tuser,   // [1:0] response_kind
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import rbmn_pkg::*;

  localparam int RAM_AW = $clog2(RAM_DEPTH);
  localparam logic [ADDR_W:0] RAM_END = (ADDR_W+1)'(RAM_BASE) + (ADDR_W+1)'(RAM_DEPTH);

  // Configuration and mapper state.
  logic [BANK_W-1:0] rom_bank_mask;
  logic [BANK_W-1:0] rom_bank;
  logic              ram_disabled;

  // Clearing pass.
  logic              clearing;
  logic [RAM_AW-1:0] clr_addr;

  // Decode stage.
  logic              s1_valid;
  resp_kind_t        s1_kind;
  logic [ROM_ADDR_W-1:0] s1_rom_address;
  logic              s1_ram_rd;
  logic              s1_open_bus;

  // Result register.
  resp_kind_t        out_kind;
  logic [ROM_ADDR_W-1:0] out_rom_address;
  logic [DATA_W-1:0] out_read_data;

  // Access fields and decode.
  logic              in_accept;
  logic              s1_adv;
  logic              is_write;
  logic [ADDR_W-1:0] bus_address;
  logic [DATA_W-1:0] write_data;
  logic              in_ram;
  logic              in_ram_window;
  logic [BANK_W-1:0] bank_sel;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [NIBBLE_W-1:0] ram_wdata;
  logic [NIBBLE_W-1:0] ram_rdata;
  logic [DATA_W-1:0] s1_read_data;
  logic              cfg_write;

  assign is_write    = (s_tuser[0] == OP_WRITE);
  assign bus_address = s_tdata[ADDR_W-1:0];
  assign write_data  = s_tdata[ADDR_W+DATA_W-1:ADDR_W];

  assign in_ram = ({1'b0, bus_address} >= {1'b0, RAM_BASE}) &&
                  ({1'b0, bus_address} < RAM_END);
  assign in_ram_window = (bus_address >= RAM_BASE) && (bus_address <= RAM_WIN_LAST);

  // Handshakes: the decode stage moves on when the result register is free.
  assign s1_adv    = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !clearing && (!s1_valid || s1_adv);
  assign in_accept = s_tvalid && s_tready;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_ROM_BANK_MASK) ? {28'd0, rom_bank_mask} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_mask <= ROM_BANK_MASK_RESET;
    end else if (cfg_write && (paddr[2] == REG_ROM_BANK_MASK)) begin
      rom_bank_mask <= pwdata[BANK_W-1:0];
    end
  end

  // Clearing pass over the RAM after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == RAM_AW'(RAM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Mapper registers change at the edge that accepts the write.
  assign bank_sel = (write_data[BANK_W-1:0] == '0) ? ROM_BANK_RESET
                                                   : write_data[BANK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank     <= ROM_BANK_RESET;
      ram_disabled <= 1'b0;
    end else if (in_accept && is_write) begin
      if (bus_address < RAM_EN_LIMIT) begin
        ram_disabled <= bus_address[8];
      end else if (bus_address < BANK_LIMIT) begin
        rom_bank <= bank_sel;
      end
    end
  end

  // RAM write port: the clearing pass, else a write into the RAM range.
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = in_accept && is_write && in_ram;
      ram_waddr = bus_address[RAM_AW-1:0];
      ram_wdata = write_data[NIBBLE_W-1:0];
    end
  end

  rbmn_ram #(
    .WIDTH (NIBBLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (bus_address[RAM_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Decode stage: response kind, ROM address and data source of a read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind        <= RESP_NONE;
      s1_rom_address <= '0;
      s1_ram_rd      <= 1'b0;
      s1_open_bus    <= 1'b0;
      if (!is_write) begin
        if (bus_address < BANK_LIMIT) begin
          s1_kind        <= RESP_ROM;
          s1_rom_address <= {{BANK_W{1'b0}}, bus_address[BANK_OFS_W-1:0]};
        end else if (bus_address < ROM_LIMIT) begin
          s1_kind        <= RESP_ROM;
          s1_rom_address <= {rom_bank & rom_bank_mask, bus_address[BANK_OFS_W-1:0]};
        end else if (in_ram) begin
          s1_kind     <= RESP_DATA;
          s1_ram_rd   <= !ram_disabled;
          s1_open_bus <= ram_disabled;
        end else if (in_ram_window) begin
          s1_kind     <= RESP_DATA;
          s1_open_bus <= 1'b1;
        end
      end
    end
  end

  // Data byte from the RAM nibble or the open-bus value.
  always_comb begin
    if (s1_ram_rd) begin
      s1_read_data = {{(DATA_W-NIBBLE_W){1'b0}}, ram_rdata};
    end else if (s1_open_bus) begin
      s1_read_data = OPEN_BUS_BYTE;
    end else begin
      s1_read_data = '0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_kind        <= s1_kind;
      out_rom_address <= s1_rom_address;
      out_read_data   <= s1_read_data;
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {6'd0, out_read_data, out_rom_address};

endmodule
